FILE: rtl/rdp_pkg.sv
// shared types, constants and helpers for the rgb to display pixel converter
package rdp_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned PixelBits  = 32;

  localparam logic [31:0] PixMask =
    (PixelBits >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PixelBits) - 64'd1);

  localparam int unsigned CfgAddrW = 5;

  localparam logic [9:0] Div3Mul   = 10'd683;
  localparam int unsigned Div3Shift = 11;

  localparam logic [1:0]  VisualModeRst = 2'd2;
  localparam logic [31:0] RedMaskRst    = 32'h00FF_0000;
  localparam logic [31:0] GreenMaskRst  = 32'h0000_FF00;
  localparam logic [31:0] BlueMaskRst   = 32'h0000_00FF;
  localparam logic [8:0]  GrayLevelsRst = 9'd256;
  localparam logic [8:0]  ColLevelsRst  = 9'd6;

  typedef enum logic [1:0] {
    ModeGray    = 2'd0,
    ModeIndexed = 2'd1,
    ModeDirect  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    RegVisualMode  = 3'd0,
    RegRedMask     = 3'd1,
    RegGreenMask   = 3'd2,
    RegBlueMask    = 3'd3,
    RegGrayLevels  = 3'd4,
    RegRedLevels   = 3'd5,
    RegGreenLevels = 3'd6,
    RegBlueLevels  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic       zero;
    logic [4:0] pos;
    logic [2:0] scale;
  } chan_info_t;

  typedef struct packed {
    logic [1:0] visual_mode;
    logic [8:0] gray_levels;
    logic [8:0] red_levels;
    logic [8:0] green_levels;
    logic [8:0] blue_levels;
    chan_info_t red_info;
    chan_info_t green_info;
    chan_info_t blue_info;
  } cfg_t;

  // lowest run of ones: position and how many low channel bits to drop
  function automatic chan_info_t mask_info(input logic [31:0] mask);
    chan_info_t  info;
    logic [31:0] lowbit;
    logic [32:0] cleared;
    logic [31:0] run;
    logic [5:0]  size;
    logic [4:0]  pos;
    lowbit  = mask & (~mask + 32'd1);
    cleared = {1'b0, mask} + {1'b0, lowbit};
    run     = mask & ~cleared[31:0];
    size    = 6'($countones(run));
    pos     = '0;
    for (int i = 0; i < 32; i++) begin
      if (lowbit[i]) begin
        pos = pos | 5'(i);
      end
    end
    info.zero  = (mask == 32'd0);
    info.pos   = pos;
    info.scale = (size >= 6'd8) ? 3'd0 : 3'(6'd8 - size);
    return info;
  endfunction

  // channel moved into its field, truncated to 32 bits
  function automatic logic [31:0] place_chan(input logic [7:0] c, input logic [4:0] pos);
    logic [39:0] w;
    w = 40'(c) << pos;
    return w[31:0];
  endfunction

endpackage

FILE: rtl/rdp_cfg.sv
// configuration register file with apb-style access and precomputed mask fields
module rdp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rdp_pkg::cfg_t                cfg_o
);

  logic [1:0]  visual_mode_q;
  logic [31:0] red_mask_q, green_mask_q, blue_mask_q;
  logic [8:0]  gray_levels_q, red_levels_q, green_levels_q, blue_levels_q;
  rdp_pkg::chan_info_t red_info_q, green_info_q, blue_info_q;
  rdp_pkg::reg_idx_e   reg_idx;
  logic                wr_en;

  assign reg_idx = rdp_pkg::reg_idx_e'(paddr[rdp_pkg::CfgAddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visual_mode_q  <= rdp_pkg::VisualModeRst;
      red_mask_q     <= rdp_pkg::RedMaskRst;
      green_mask_q   <= rdp_pkg::GreenMaskRst;
      blue_mask_q    <= rdp_pkg::BlueMaskRst;
      gray_levels_q  <= rdp_pkg::GrayLevelsRst;
      red_levels_q   <= rdp_pkg::ColLevelsRst;
      green_levels_q <= rdp_pkg::ColLevelsRst;
      blue_levels_q  <= rdp_pkg::ColLevelsRst;
    end else if (wr_en) begin
      case (reg_idx)
        rdp_pkg::RegVisualMode:  visual_mode_q  <= pwdata[1:0];
        rdp_pkg::RegRedMask:     red_mask_q     <= pwdata;
        rdp_pkg::RegGreenMask:   green_mask_q   <= pwdata;
        rdp_pkg::RegBlueMask:    blue_mask_q    <= pwdata;
        rdp_pkg::RegGrayLevels:  gray_levels_q  <= pwdata[8:0];
        rdp_pkg::RegRedLevels:   red_levels_q   <= pwdata[8:0];
        rdp_pkg::RegGreenLevels: green_levels_q <= pwdata[8:0];
        rdp_pkg::RegBlueLevels:  blue_levels_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // mask fields are registered from the mask registers and follow them in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_info_q   <= rdp_pkg::mask_info(rdp_pkg::RedMaskRst);
      green_info_q <= rdp_pkg::mask_info(rdp_pkg::GreenMaskRst);
      blue_info_q  <= rdp_pkg::mask_info(rdp_pkg::BlueMaskRst);
    end else begin
      red_info_q   <= rdp_pkg::mask_info(red_mask_q);
      green_info_q <= rdp_pkg::mask_info(green_mask_q);
      blue_info_q  <= rdp_pkg::mask_info(blue_mask_q);
    end
  end

  always_comb begin
    case (reg_idx)
      rdp_pkg::RegVisualMode:  prdata = 32'(visual_mode_q);
      rdp_pkg::RegRedMask:     prdata = red_mask_q;
      rdp_pkg::RegGreenMask:   prdata = green_mask_q;
      rdp_pkg::RegBlueMask:    prdata = blue_mask_q;
      rdp_pkg::RegGrayLevels:  prdata = 32'(gray_levels_q);
      rdp_pkg::RegRedLevels:   prdata = 32'(red_levels_q);
      rdp_pkg::RegGreenLevels: prdata = 32'(green_levels_q);
      rdp_pkg::RegBlueLevels:  prdata = 32'(blue_levels_q);
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg_o.visual_mode  = visual_mode_q;
    cfg_o.gray_levels  = gray_levels_q;
    cfg_o.red_levels   = red_levels_q;
    cfg_o.green_levels = green_levels_q;
    cfg_o.blue_levels  = blue_levels_q;
    cfg_o.red_info     = red_info_q;
    cfg_o.green_info   = green_info_q;
    cfg_o.blue_info    = blue_info_q;
  end

endmodule

FILE: rtl/rgb_to_display_pixel_top.sv
// top level: five-stage pixel conversion pipeline with the pixel lookup table
//
// Converts an RGB888 request into a display pixel by gray lookup, colour-cube
// lookup or direct mask packing, or loads one lookup table entry. One request
// is taken every cycle when the output is not stalled, and its result passes
// through stages 1 to 5 to the output. Each request uses the single table
// port at most once, in stage 5, so loads and lookups stay in request order.
// Stages hold their data under backpressure and bubbles are squeezed out.
// Table entries hold no value until loaded; there is no clearing pass after
// reset. Mask register writes take effect through the registered mask fields.
module rgb_to_display_pixel_top #(
  parameter int unsigned TABLE_DEPTH = rdp_pkg::TableDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [7:0]                   red_i,
  input  logic [7:0]                   green_i,
  input  logic [7:0]                   blue_i,
  input  logic [7:0]                   entry_index_i,
  input  logic [31:0]                  entry_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  pixel_o,
  output logic                         index_error_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [27:0] DepthW = 28'(TABLE_DEPTH);

  rdp_pkg::cfg_t cfg;

  rdp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  // stage 1: captured request
  logic        op1_q;
  logic [7:0]  r1_q, g1_q, b1_q, ei1_q;
  logic [31:0] ep1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op1_q <= opcode_i;
      r1_q  <= red_i;
      g1_q  <= green_i;
      b1_q  <= blue_i;
      ei1_q <= entry_index_i;
      ep1_q <= entry_pixel_i;
    end
  end

  // stage 2: channel sum, per-channel quantization, channel reduction
  logic [16:0] rprod, gprod, bprod;
  logic        op2_q;
  logic [7:0]  ei2_q;
  logic [31:0] ep2_q;
  logic [9:0]  sum2_q;
  logic [8:0]  rq2_q, gq2_q, bq2_q;
  logic [7:0]  dr2_q, dg2_q, db2_q;

  assign rprod = 17'(r1_q) * 17'(cfg.red_levels);
  assign gprod = 17'(g1_q) * 17'(cfg.green_levels);
  assign bprod = 17'(b1_q) * 17'(cfg.blue_levels);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      op2_q  <= op1_q;
      ei2_q  <= ei1_q;
      ep2_q  <= ep1_q;
      sum2_q <= 10'(r1_q) + 10'(g1_q) + 10'(b1_q);
      rq2_q  <= rprod[16:8];
      gq2_q  <= gprod[16:8];
      bq2_q  <= bprod[16:8];
      dr2_q  <= cfg.red_info.zero   ? 8'd0 : (r1_q >> cfg.red_info.scale);
      dg2_q  <= cfg.green_info.zero ? 8'd0 : (g1_q >> cfg.green_info.scale);
      db2_q  <= cfg.blue_info.zero  ? 8'd0 : (b1_q >> cfg.blue_info.scale);
    end
  end

  // stage 3: divide by three, cube partial products, direct packing
  logic [19:0] yprod;
  logic        op3_q;
  logic [7:0]  ei3_q;
  logic [31:0] ep3_q;
  logic [7:0]  y3_q;
  logic [17:0] rg3_q, gb3_q;
  logic [8:0]  bq3_q;
  logic [31:0] direct3_q;

  assign yprod = 20'(sum2_q) * 20'(rdp_pkg::Div3Mul);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      op3_q     <= op2_q;
      ei3_q     <= ei2_q;
      ep3_q     <= ep2_q;
      y3_q      <= yprod[rdp_pkg::Div3Shift +: 8];
      rg3_q     <= 18'(rq2_q) * 18'(cfg.green_levels);
      gb3_q     <= 18'(gq2_q) * 18'(cfg.blue_levels);
      bq3_q     <= bq2_q;
      direct3_q <= (rdp_pkg::place_chan(dr2_q, cfg.red_info.pos)
                  + rdp_pkg::place_chan(dg2_q, cfg.green_info.pos)
                  + rdp_pkg::place_chan(db2_q, cfg.blue_info.pos)) & rdp_pkg::PixMask;
    end
  end

  // stage 4: gray scaling, full cube product
  logic [16:0] gprod4;
  logic        op4_q;
  logic [7:0]  ei4_q;
  logic [31:0] data4_q;
  logic [8:0]  gidx4_q;
  logic [26:0] rgb4_q;
  logic [18:0] gb4_q;

  assign gprod4 = 17'(y3_q) * 17'(cfg.gray_levels);

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      op4_q   <= op3_q;
      ei4_q   <= ei3_q;
      data4_q <= op3_q ? ep3_q : direct3_q;
      gidx4_q <= gprod4[16:8];
      rgb4_q  <= 27'(rg3_q) * 27'(cfg.blue_levels);
      gb4_q   <= 19'(gb3_q) + 19'(bq3_q);
    end
  end

  // stage 5: index select, range check, table access
  logic [27:0]      idx4;
  logic             lookup4, err4, wr4, rd4;
  logic [AddrW-1:0] addr4;
  logic [31:0]      pix_table_q [TABLE_DEPTH];
  logic [31:0]      rdata_q;
  logic             lookup5_q, err5_q;
  logic [31:0]      data5_q;

  always_comb begin
    case (cfg.visual_mode)
      rdp_pkg::ModeGray: begin
        idx4    = 28'(gidx4_q);
        lookup4 = !op4_q;
      end
      rdp_pkg::ModeIndexed: begin
        idx4    = 28'(rgb4_q) + 28'(gb4_q);
        lookup4 = !op4_q;
      end
      default: begin
        idx4    = 28'(gidx4_q);
        lookup4 = 1'b0;
      end
    endcase
    if (op4_q) begin
      err4  = 28'(ei4_q) >= DepthW;
      addr4 = AddrW'(ei4_q);
    end else begin
      err4  = lookup4 && (idx4 >= DepthW);
      addr4 = idx4[AddrW-1:0];
    end
    wr4 = rdy5 && v4_q && op4_q && !err4;
    rd4 = rdy5 && v4_q && lookup4 && !err4;
  end

  always_ff @(posedge clk_i) begin
    if (wr4) begin
      pix_table_q[addr4] <= data4_q;
    end else if (rd4) begin
      rdata_q <= pix_table_q[addr4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      lookup5_q <= lookup4;
      err5_q    <= err4;
      data5_q   <= data4_q;
    end
  end

  assign out_valid_o   = v5_q;
  assign index_error_o = err5_q;
  assign pixel_o       = lookup5_q ? (err5_q ? 32'd0 : (rdata_q & rdp_pkg::PixMask))
                                   : data5_q;

endmodule
